// ----- src/hgr_pkg.sv -----
// ----------------------------------------------------------------------------
// hgr_pkg: shared types and constants of the hanzi glyph rasterizer
// Item layouts, command codes, result kinds, font geometry tables and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hgr_pkg;

  // Input command codes (s_tuser)
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Result kinds (m_tuser)
  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Code bases for small and large fonts
  localparam logic [15:0] CODE_BASE_SMALL = 16'hA0A0;
  localparam logic [15:0] CODE_BASE_LARGE = 16'hAFA0;
  localparam logic [3:0]  FIRST_LARGE_FONT = 4'd4;
  localparam logic [3:0]  LAST_FONT        = 4'd12;

  // Area/position limits and area stride
  localparam logic [7:0]  AREA_MAX   = 8'd94;
  localparam logic [13:0] ROW_STRIDE = 14'd94;

  localparam int TDATA_BITS = 72;

  // Input item, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [7:0]         font_byte;
    logic [3:0]         back_color;
    logic [3:0]         text_color;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_x;
    logic [3:0]         font_choice;
    logic [15:0]        char_code;
    logic               enable;
  } in_data_t;

  // Result item data
  typedef struct packed {
    logic [4:0]  pad;
    logic [3:0]  pixel_color;
    logic [15:0] pixel_y;
    logic [15:0] pixel_x;
    logic [8:0]  fetch_count;
    logic [21:0] fetch_address;
  } out_data_t;

  // Controller -> datapath
  typedef struct packed {
    logic take;        // input item accepted this cycle
    logic load_fetch;  // load fetch or error result
    logic load_pixel;  // load next pixel result
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic start_go;    // enabled start item at input
    logic byte_go;     // font byte at input for a glyph in progress
    logic k_last;      // eighth pixel of the byte is next
    logic out_free;    // output register can be loaded
  } dp_status_t;

  // Glyph lines per font
  function automatic logic [5:0] font_lines(input logic [3:0] font);
    logic [5:0] n;
    case (font)
      4'd0: n = 6'd12;
      4'd1: n = 6'd14;
      4'd2, 4'd3: n = 6'd16;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: n = 6'd24;
      4'd9, 4'd10: n = 6'd40;
      4'd11, 4'd12: n = 6'd48;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  // Bytes per glyph line per font
  function automatic logic [2:0] font_rbytes(input logic [3:0] font);
    logic [2:0] n;
    case (font)
      4'd0, 4'd1, 4'd2, 4'd3: n = 3'd2;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: n = 3'd3;
      4'd9, 4'd10: n = 3'd5;
      4'd11, 4'd12: n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Bytes per glyph per font
  function automatic logic [8:0] font_bytes(input logic [3:0] font);
    logic [8:0] n;
    case (font)
      4'd0: n = 9'd24;
      4'd1: n = 9'd28;
      4'd2, 4'd3: n = 9'd32;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: n = 9'd72;
      4'd9, 4'd10: n = 9'd200;
      4'd11, 4'd12: n = 9'd288;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/hanzi_glyph_rasterizer.sv -----
// ----------------------------------------------------------------------------
// hanzi_glyph_rasterizer: GB2312 bitmap font glyph renderer
// Turns start items into font-memory fetch requests and font bytes into
// pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tuser selects a start item (glyph, font, origin, colors)
//   or one font bitmap byte. Master channel: m_tuser gives the result kind
//   (fetch request, pixel, error); m_tlast marks the final glyph pixel.
//   A start item yields one fetch or error item: acceptance registers the
//   glyph setup, then the address state forms the address product and loads
//   the item into the output register once it is free; s_tready is low there.
//   A font byte yields eight pixel items, one per cycle while the receiver
//   does not stall, from one output register; the next item is accepted in
//   the cycle the eighth pixel is loaded.
//   A disabled start or a byte with no glyph in progress yields nothing.
//   When the receiver stalls, the output register holds its item and the
//   pixel sequence pauses; s_tready stays low while results of the current
//   item still wait to be loaded.
//   Reset (synchronous) empties the output register and drops any glyph in
//   progress.
// ----------------------------------------------------------------------------
module hanzi_glyph_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // enable, char_code, font_choice, origin_x, origin_y, text_color,
  // back_color, font_byte, zero pad
  input  logic [71:0] s_tdata,
  // cmd
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // fetch_address, fetch_count, pixel_x, pixel_y, pixel_color, zero pad
  output logic [71:0] m_tdata,
  // kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  hgr_pkg::dp_cmd_t    cmd;
  hgr_pkg::dp_status_t status;

  // Sequencer
  hgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath and output register
  hgr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- src/hgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// hgr_ctrl: sequencing controller
// Accepts items, steps the fetch result and the eight pixels of each byte.
// ----------------------------------------------------------------------------
module hgr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  hgr_pkg::dp_status_t status,
  output hgr_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_PIX  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       byte_end;
  logic [1:0] after_take;

  // Eighth pixel leaves this cycle
  assign byte_end = (state == S_PIX) && status.out_free && status.k_last;

  assign s_tready = (state == S_IDLE) || byte_end;

  assign cmd.take       = s_tvalid && s_tready;
  assign cmd.load_fetch = (state == S_ADDR) && status.out_free;
  assign cmd.load_pixel = (state == S_PIX) && status.out_free;

  // Where an accepted item leads
  always_comb begin
    if (status.start_go) begin
      after_take = S_ADDR;
    end else if (status.byte_go) begin
      after_take = S_PIX;
    end else begin
      after_take = S_IDLE;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take) begin
          state_next = after_take;
        end
      end
      S_ADDR: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_PIX: begin
        if (byte_end) begin
          state_next = cmd.take ? after_take : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/hgr_datapath.sv -----
// ----------------------------------------------------------------------------
// hgr_datapath: glyph state, address arithmetic and result register
// Decodes items, holds glyph geometry and position counters, forms the
// fetch address and the pixel coordinates, and drives the output register.
// ----------------------------------------------------------------------------
module hgr_datapath #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hgr_pkg::TDATA_BITS-1:0]       s_tdata,
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [hgr_pkg::TDATA_BITS-1:0]       m_tdata,
  output logic [1:0]                           m_tuser,
  output logic                                 m_tlast,
  input  hgr_pkg::dp_cmd_t                     cmd,
  output hgr_pkg::dp_status_t                  status
);

  hgr_pkg::in_data_t  din;
  hgr_pkg::out_data_t dout;

  // Input decode
  logic [15:0]           rel_code;
  logic [7:0]            area;
  logic [7:0]            pos;
  logic                  bad_in;
  logic [13:0]           index_in;
  logic [5:0]            lines_in;

  // Glyph state
  logic                  active;
  logic                  active_eff;
  logic [5:0]            glyph_lines;
  logic [2:0]            row_bytes;
  logic                  transposed;
  logic [5:0]            line_count;
  logic [2:0]            byte_column;
  logic [COORD_BITS-1:0] base_x;
  logic [COORD_BITS-1:0] base_y;
  logic [3:0]            fg_color;
  logic [3:0]            bg_color;
  logic                  bad;
  logic [13:0]           glyph_index;
  logic [8:0]            glyph_bytes;
  logic [7:0]            shift_byte;
  logic [2:0]            k;

  // Pixel position
  logic [5:0]            along;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic                  final_byte;
  logic [21:0]           fetch_addr;

  assign din = s_tdata;

  // Area and position relative to the font's code base
  assign rel_code = din.char_code - ((din.font_choice < hgr_pkg::FIRST_LARGE_FONT) ?
                    hgr_pkg::CODE_BASE_SMALL : hgr_pkg::CODE_BASE_LARGE);
  assign area = rel_code[15:8];
  assign pos  = rel_code[7:0];
  assign bad_in = (din.font_choice > hgr_pkg::LAST_FONT) ||
                  (area == 8'd0) || (area > hgr_pkg::AREA_MAX) ||
                  (pos == 8'd0) || (pos > hgr_pkg::AREA_MAX);
  assign index_in = 14'(area - 8'd1) * hgr_pkg::ROW_STRIDE + 14'(pos - 8'd1);
  assign lines_in = hgr_pkg::font_lines(din.font_choice);

  // Last byte of the glyph
  assign final_byte = (line_count == glyph_lines - 6'd1) &&
                      (byte_column == row_bytes - 3'd1);
  assign active_eff = active && !(cmd.load_pixel && status.k_last && final_byte);

  assign status.start_go = (s_tuser == hgr_pkg::CMD_START) && din.enable;
  assign status.byte_go  = (s_tuser == hgr_pkg::CMD_BYTE) && active_eff;
  assign status.k_last   = (k == 3'd7);
  assign status.out_free = !m_tvalid || m_tready;

  // Pixel coordinates
  assign along = {byte_column, k};
  assign px = transposed ? base_x + COORD_BITS'(line_count) : base_x + COORD_BITS'(along);
  assign py = transposed ? base_y + COORD_BITS'(along) : base_y + COORD_BITS'(line_count);

  assign fetch_addr = 22'(glyph_bytes) * 22'(glyph_index);

  // Pixel stepping within a byte; a new byte restarts it
  always_ff @(posedge clk) begin
    if (cmd.take && status.byte_go) begin
      shift_byte <= din.font_byte;
      k          <= 3'd0;
    end else if (cmd.load_pixel) begin
      k          <= k + 3'd1;
      shift_byte <= {shift_byte[6:0], 1'b0};
    end
  end

  // Byte and line position; a valid start clears it
  always_ff @(posedge clk) begin
    if (cmd.take && status.start_go && !bad_in) begin
      line_count  <= 6'd0;
      byte_column <= 3'd0;
    end else if (cmd.load_pixel && status.k_last) begin
      if (byte_column + 3'd1 >= row_bytes) begin
        byte_column <= 3'd0;
        line_count  <= line_count + 6'd1;
      end else begin
        byte_column <= byte_column + 3'd1;
      end
    end
  end

  // Glyph setup on a start item
  always_ff @(posedge clk) begin
    if (cmd.take && (s_tuser == hgr_pkg::CMD_START)) begin
      bad         <= bad_in;
      glyph_index <= index_in;
      glyph_bytes <= hgr_pkg::font_bytes(din.font_choice);
      if (din.enable && !bad_in) begin
        glyph_lines <= lines_in;
        row_bytes   <= hgr_pkg::font_rbytes(din.font_choice);
        transposed  <= (hgr_pkg::font_rbytes(din.font_choice) == 3'd3);
        base_x      <= COORD_BITS'(din.origin_x);
        base_y      <= COORD_BITS'(din.origin_y) - COORD_BITS'(lines_in);
        fg_color    <= din.text_color;
        bg_color    <= din.back_color;
      end
    end
  end

  // Glyph in progress flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.take && (s_tuser == hgr_pkg::CMD_START)) begin
      active <= din.enable && !bad_in;
    end else begin
      active <= active_eff;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_fetch || cmd.load_pixel) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fetch) begin
      m_tuser            <= bad ? hgr_pkg::KIND_ERROR : hgr_pkg::KIND_FETCH;
      m_tlast            <= 1'b0;
      dout.pad           <= '0;
      dout.fetch_address <= bad ? 22'd0 : fetch_addr;
      dout.fetch_count   <= bad ? 9'd0 : glyph_bytes;
      dout.pixel_x       <= 16'd0;
      dout.pixel_y       <= 16'd0;
      dout.pixel_color   <= 4'd0;
    end else if (cmd.load_pixel) begin
      m_tuser            <= hgr_pkg::KIND_PIXEL;
      m_tlast            <= final_byte && status.k_last;
      dout.pad           <= '0;
      dout.fetch_address <= 22'd0;
      dout.fetch_count   <= 9'd0;
      dout.pixel_x       <= 16'(px);
      dout.pixel_y       <= 16'(py);
      dout.pixel_color   <= shift_byte[7] ? fg_color : bg_color;
    end
  end

  assign m_tdata = dout;

endmodule

// ----- src/hgr_checker.sv -----
// ----------------------------------------------------------------------------
// hgr_checker: port-level checks of the glyph rasterizer
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module hgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // End-of-glyph mark only on pixels
  a_last_pixel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == hgr_pkg::KIND_PIXEL)
    else $error("tlast on a non-pixel item");

  // A fetch always asks for a nonzero byte count
  a_fetch_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == hgr_pkg::KIND_FETCH) |-> m_tdata[30:22] != 9'd0)
    else $error("fetch with zero byte count");

endmodule

bind hanzi_glyph_rasterizer hgr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for hanzi_glyph_rasterizer
// Drives start items and font bytes into the slave stream and predicts the
// fetch, error and pixel items for every accepted input. A scoreboard class
// compares each master-side item in order, field by field. Both stream sides
// idle in random bursts, and the sender drains the block once mid-run.
// ----------------------------------------------------------------------------
module tb_top;

  // One expected or observed result item
  typedef struct {
    logic [1:0]  kind;
    logic [21:0] addr;
    logic [8:0]  cnt;
    logic [15:0] px;
    logic [15:0] py;
    logic [3:0]  color;
    logic        last;
  } glyph_result_t;

  // Glyph height in lines for a font index
  function automatic int lines_of(input logic [3:0] font);
    if (font < 1) return 12;
    if (font < 2) return 14;
    if (font < 4) return 16;
    if (font < 9) return 24;
    if (font < 11) return 40;
    return 48;
  endfunction

  // Bytes per glyph line for a font index
  function automatic int row_bytes_of(input logic [3:0] font);
    if (font < hgr_pkg::FIRST_LARGE_FONT) return 2;
    if (font < 9) return 3;
    if (font < 11) return 5;
    return 6;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: glyph predictor plus in-order result queue
  // --------------------------------------------------------------------------
  class glyph_scoreboard;
    glyph_result_t due_results[$];
    int            mismatches = 0;
    bit            drawing    = 0;
    int            lines, rbytes, line_no, col_no;
    bit            column_major;
    logic [15:0]   org_x, org_y;
    logic [3:0]    fg, bg;

    function automatic glyph_result_t blank(input logic [1:0] kind);
      glyph_result_t r;
      r.kind  = kind;
      r.addr  = '0;
      r.cnt   = '0;
      r.px    = '0;
      r.py    = '0;
      r.color = '0;
      r.last  = 1'b0;
      return r;
    endfunction

    function automatic string fmt(input glyph_result_t r);
      return $sformatf("kind=%0d addr=%0h cnt=%0d x=%0d y=%0d color=%0h last=%0b",
                       r.kind, r.addr, r.cnt, $signed(r.px), $signed(r.py),
                       r.color, r.last);
    endfunction

    // Accepted input item: queue what it should produce, return that count
    function automatic int take_item(input logic cmd, input hgr_pkg::in_data_t d);
      logic [15:0]   offs;
      logic [7:0]    area, pos;
      int            nbytes, along;
      bit            final_byte;
      glyph_result_t r;
      if (cmd == hgr_pkg::CMD_START) begin
        drawing = 0;
        if (!d.enable) return 0;
        if (d.font_choice > hgr_pkg::LAST_FONT) begin
          due_results.push_back(blank(hgr_pkg::KIND_ERROR));
          return 1;
        end
        offs = d.char_code - ((d.font_choice < hgr_pkg::FIRST_LARGE_FONT) ?
                              hgr_pkg::CODE_BASE_SMALL : hgr_pkg::CODE_BASE_LARGE);
        area = offs[15:8];
        pos  = offs[7:0];
        if (area < 1 || area > hgr_pkg::AREA_MAX || pos < 1 || pos > hgr_pkg::AREA_MAX) begin
          due_results.push_back(blank(hgr_pkg::KIND_ERROR));
          return 1;
        end
        lines        = lines_of(d.font_choice);
        rbytes       = row_bytes_of(d.font_choice);
        column_major = (rbytes == 3);
        nbytes       = lines * rbytes;
        line_no      = 0;
        col_no       = 0;
        org_x        = d.origin_x;
        org_y        = d.origin_y - 16'(lines);
        fg           = d.text_color;
        bg           = d.back_color;
        drawing      = 1;
        r            = blank(hgr_pkg::KIND_FETCH);
        r.addr       = 22'(nbytes * (94 * (int'(area) - 1) + int'(pos) - 1));
        r.cnt        = 9'(nbytes);
        due_results.push_back(r);
        return 1;
      end
      if (!drawing) return 0;
      // One font byte expands to eight pixels, MSB first
      final_byte = (line_no + 1 == lines) && (col_no + 1 == rbytes);
      for (int k = 0; k < 8; k++) begin
        along   = col_no * 8 + k;
        r       = blank(hgr_pkg::KIND_PIXEL);
        r.color = d.font_byte[7-k] ? fg : bg;
        if (column_major) begin
          r.px = org_x + 16'(line_no);
          r.py = org_y + 16'(along);
        end else begin
          r.px = org_x + 16'(along);
          r.py = org_y + 16'(line_no);
        end
        r.last = final_byte && (k == 7);
        due_results.push_back(r);
      end
      col_no++;
      if (col_no >= rbytes) begin
        col_no = 0;
        line_no++;
        if (line_no >= lines) drawing = 0;
      end
      return 8;
    endfunction

    function automatic void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Observed result item: compare with the oldest expectation
    function automatic void check_result(input logic [1:0] kind,
                                         input hgr_pkg::out_data_t d,
                                         input logic last);
      glyph_result_t got, want;
      got.kind  = kind;
      got.addr  = d.fetch_address;
      got.cnt   = d.fetch_count;
      got.px    = d.pixel_x;
      got.py    = d.pixel_y;
      got.color = d.pixel_color;
      got.last  = last;
      if (due_results.size() == 0) begin
        flag({"unexpected item: ", fmt(got)});
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.addr !== want.addr || got.cnt !== want.cnt ||
          got.px !== want.px || got.py !== want.py || got.color !== want.color ||
          got.last !== want.last)
        flag({"exp ", fmt(want), " / got ", fmt(got)});
    endfunction

    function automatic int pending();
      return due_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;
  logic        s_tuser  = hgr_pkg::CMD_START;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  glyph_scoreboard sb = new();
  bit calm     = 0;   // no idling on either side
  int gap_pct  = 0;   // sender gap chance per item
  int sent     = 0;   // accepted items that produce results

  always #5 clk = ~clk;

  hanzi_glyph_rasterizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Receiver: random stall bursts, with quiet stretches between
  int stall_left = 0;
  int quiet_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && quiet_left == 0 && $urandom_range(0, 99) < 10) begin
      stall_left <= $urandom_range(0, 9);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (quiet_left != 0) quiet_left <= quiet_left - 1;
      else if ($urandom_range(0, 99) < 3) quiet_left <= $urandom_range(30, 80);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, hgr_pkg::out_data_t'(m_tdata), m_tlast);
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input hgr_pkg::in_data_t d);
    int n;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    n = sb.take_item(cmd, d);
    if (n > 0) sent++;
  endtask

  task automatic send_start(input logic en, input logic [15:0] code, input logic [3:0] font,
                            input logic [15:0] ox, input logic [15:0] oy,
                            input logic [3:0] fgc, input logic [3:0] bgc);
    hgr_pkg::in_data_t d;
    d             = '0;
    d.enable      = en;
    d.char_code   = code;
    d.font_choice = font;
    d.origin_x    = ox;
    d.origin_y    = oy;
    d.text_color  = fgc;
    d.back_color  = bgc;
    d.font_byte   = 8'($urandom);
    send_item(hgr_pkg::CMD_START, d);
  endtask

  task automatic send_byte(input logic [7:0] b);
    hgr_pkg::in_data_t d;
    d             = '0;
    d.enable      = 1'($urandom);
    d.char_code   = 16'($urandom);
    d.font_choice = 4'($urandom);
    d.origin_x    = 16'($urandom);
    d.origin_y    = 16'($urandom);
    d.text_color  = 4'($urandom);
    d.back_color  = 4'($urandom);
    d.font_byte   = b;
    send_item(hgr_pkg::CMD_BYTE, d);
  endtask

  function automatic logic [15:0] code_for(input logic [3:0] font, input logic [7:0] area,
                                           input logic [7:0] pos);
    return ((font < hgr_pkg::FIRST_LARGE_FONT) ? hgr_pkg::CODE_BASE_SMALL :
            hgr_pkg::CODE_BASE_LARGE) + {area, pos};
  endfunction

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rand_font_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Start a valid glyph and deliver nb of its bytes
  task automatic draw_glyph(input logic [3:0] font, input int nb);
    send_start(1'b1, code_for(font, 8'($urandom_range(1, 94)), 8'($urandom_range(1, 94))),
               font, rand_coord(), rand_coord(), 4'($urandom), 4'($urandom));
    repeat (nb) send_byte(rand_font_byte());
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          r, nb;
    logic [3:0]  f;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    gap_pct = 30;
    send_byte(8'hA5);                                            // byte while idle
    send_start(1'b0, 16'hA1A1, 4'd0, 16'h0, 16'h0, 4'hF, 4'h0);  // disabled start
    send_start(1'b1, 16'hA1A1, 4'd13, 16'h0, 16'h0, 4'h1, 4'h2); // bad fonts
    send_start(1'b1, 16'hA1A1, 4'd15, 16'h0, 16'h0, 4'h1, 4'h2);
    send_start(1'b1, 16'hA0A1, 4'd0, 16'h0, 16'h0, 4'h1, 4'h2);  // area 0
    send_start(1'b1, code_for(4'd4, 8'd95, 8'd1), 4'd4, 16'h0, 16'h0, 4'h1, 4'h2);
    send_start(1'b1, 16'hA1A0, 4'd1, 16'h0, 16'h0, 4'h1, 4'h2);  // position 0
    send_start(1'b1, 16'hA1FF, 4'd2, 16'h0, 16'h0, 4'h1, 4'h2);  // position 95
    // smallest address, most negative origin
    send_start(1'b1, code_for(4'd0, 8'd1, 8'd1), 4'd0, 16'h8000, 16'h8000, 4'hF, 4'h0);
    send_byte(8'hFF);
    send_byte(8'h00);
    // column-major font, largest origin, last area and position
    send_start(1'b1, code_for(4'd4, 8'd94, 8'd94), 4'd4, 16'h7FFF, 16'h7FFF, 4'h0, 4'hF);
    send_byte(8'h80);
    send_byte(8'h01);
    // new start while a glyph is in progress abandons it
    send_start(1'b1, code_for(4'd12, 8'd94, 8'd94), 4'd12, 16'h0100, 16'h0100, 4'h5, 4'hA);
    send_byte(8'h5A);
    send_start(1'b1, code_for(4'd9, 8'd47, 8'd3), 4'd9, 16'hFFF0, 16'h0010, 4'h3, 4'hC);
    send_byte(8'hC3);
    // disabled start drops the glyph, the next byte is ignored
    send_start(1'b0, code_for(4'd2, 8'd16, 8'd37), 4'd2, 16'h0, 16'h0, 4'h0, 4'h0);
    send_byte(8'h3C);
    // hold off until the block has drained
    s_tvalid <= 1'b0;
    wait_idle();
    send_start(1'b1, code_for(4'd10, 8'd1, 8'd94), 4'd10, 16'h0, 16'h0, 4'h9, 4'h6);
    send_start(1'b1, code_for(4'd7, 8'd94, 8'd1), 4'd7, 16'h1234, 16'h8765, 4'hE, 4'h1);

    // Random part: mostly whole glyphs, some noise and cut-off glyphs
    while (sent < 350) begin
      calm = (sent >= 290);
      if ($urandom_range(0, 3) == 0) begin
        r       = $urandom_range(0, 2);
        gap_pct = (r == 0) ? 0 : (r == 1) ? 25 : 60;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        f  = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(9, 12)) : 4'($urandom_range(0, 8));
        nb = lines_of(f) * row_bytes_of(f);
        if ($urandom_range(0, 4) == 0) nb = $urandom_range(0, nb - 1);
        if (nb > 350 - sent) nb = 350 - sent;
        draw_glyph(f, nb);
      end else if (r < 76) begin
        send_start(1'b1, 16'($urandom), 4'($urandom_range(13, 15)), rand_coord(),
                   rand_coord(), 4'($urandom), 4'($urandom));
      end else if (r < 82) begin
        send_start(1'b1, 16'($urandom), 4'($urandom_range(0, 12)), rand_coord(),
                   rand_coord(), 4'($urandom), 4'($urandom));
      end else if (r < 88) begin
        send_start(1'b0, 16'($urandom), 4'($urandom), rand_coord(), rand_coord(),
                   4'($urandom), 4'($urandom));
      end else if (r < 94) begin
        send_byte(8'($urandom));
      end else begin
        send_start(1'($urandom), 16'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                   4'($urandom), 4'($urandom));
      end
    end

    s_tvalid <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
